[sv/eldt_pkg.sv]
// Shared types, widths and constants of the envelope level duration tracker.
package eldt_pkg;

   localparam int INDEX_BITS_DEFAULT = 20;
   localparam int POWER_BITS_DEFAULT = 32;

   localparam int POWER_IN_BITS = 32;
   localparam int DURATION_BITS = 20;
   localparam int RATE_BITS     = 10;
   localparam int RATIO_BITS    = 16;
   localparam int MIN_DUR_BITS  = 20;
   localparam int SMOOTH_BITS   = 16;
   localparam int FRAC_BITS     = 16;
   localparam int BLEND_BITS    = FRAC_BITS + 1;
   localparam int DIV_BITS      = 17;
   localparam int NUM_LEVELS    = 4;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 20;

   localparam logic [DURATION_BITS-1:0] DURATION_MAX = '1;
   localparam logic [BLEND_BITS-1:0]    Q16_ONE      = 17'h10000;
   localparam logic [BLEND_BITS-1:0]    Q16_HALF     = 17'h08000;

   localparam logic [RATE_BITS-1:0]     RESET_SAMPLE_RATE    = 10'd100;
   localparam logic [MIN_DUR_BITS-1:0]  RESET_MIN_DURATION   = 20'd1000;
   localparam logic [SMOOTH_BITS-1:0]   RESET_TWICE_SMOOTH   = 16'd200;
   localparam logic [RATIO_BITS-1:0]    RESET_NOISE_RATIO    = 16'd512;
   localparam logic [RATIO_BITS-1:0]    RESET_PEAK_RATIO     = 16'd3277;
   localparam logic [DURATION_BITS-1:0] RESET_DURATION_FLOOR = 20'd500;
   localparam logic [DURATION_BITS-1:0] RESET_FIXED_DURATION = 20'd0;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SAMPLE_RATE,
      CSR_MIN_DURATION,
      CSR_TWICE_SMOOTH,
      CSR_NOISE_RATIO_END,
      CSR_PEAK_RATIO_END,
      CSR_DURATION_FLOOR,
      CSR_FIXED_DURATION
   } eldt_csr_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_MULT,
      S_EVAL,
      S_DIVSET,
      S_DIV,
      S_BLEND_GO,
      S_BLEND,
      S_DTERM,
      S_OUT
   } eldt_state_type;

   typedef struct packed {
      logic active;
      logic resolved;
      logic terminated;
   } eldt_status_type;

endpackage

[sv/eldt_if.sv]
// Valid/ready channel interfaces for the tracker's input and result items.
interface eldt_req_if;
   logic                                valid;
   logic                                ready;
   logic [eldt_pkg::POWER_IN_BITS-1:0]  power;
   logic                                first_sample;

   modport source (output valid, output power, output first_sample, input ready);
   modport sink (input valid, input power, input first_sample, output ready);
endinterface

interface eldt_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                resolved;
   logic                                terminated;
   logic [eldt_pkg::DURATION_BITS-1:0]  duration_samples;
   logic [eldt_pkg::DURATION_BITS-1:0]  peak_index;

   modport source (output valid, output resolved, output terminated,
                   output duration_samples, output peak_index, input ready);
   modport sink (input valid, input resolved, input terminated,
                 input duration_samples, input peak_index, output ready);
endinterface

[sv/envelope_level_duration_tracker_core.sv]
// Top level of the envelope level duration tracker: control, level state and result register.
//
// The tracker takes one power item at a time and returns one result item per input item.
// A pick item, or an item that arrives before a pick, after termination or in fixed-duration
// mode, passes from the check state to the output state and the result register. A normal
// search item also waits on the two 16-bit bit-serial ratio multipliers. An item that crosses
// the 20 percent level adds the 17-step serial blend multipliers and, when the blend factor
// is strictly between 0 and 1, the 16-step serial divider. A new item is accepted as soon
// as the previous one has been placed in the result register, even if that result has not
// yet been taken.
module envelope_level_duration_tracker_core #(
   parameter int INDEX_BITS = eldt_pkg::INDEX_BITS_DEFAULT,
   parameter int POWER_BITS = eldt_pkg::POWER_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   eldt_req_if.sink                              req_ch,
   eldt_rsp_if.source                            rsp_ch,
   input  logic                                  csr_write_en,
   input  logic [eldt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [eldt_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   localparam int IW   = INDEX_BITS;
   localparam int PW   = POWER_BITS;
   localparam int DW   = eldt_pkg::DURATION_BITS;
   localparam int HW   = (IW > DW) ? IW : DW;
   localparam int AW   = (PW > eldt_pkg::POWER_IN_BITS) ? PW : eldt_pkg::POWER_IN_BITS;
   localparam int CW   = PW + 4;
   localparam int PPW  = PW + eldt_pkg::RATIO_BITS;
   localparam int BB   = eldt_pkg::BLEND_BITS;
   localparam int BPW  = IW + BB;
   localparam int BSW  = BPW + 1;
   localparam int DVW  = eldt_pkg::DIV_BITS;
   localparam int SW   = (IW + 1 > DVW) ? IW + 1 : DVW;
   localparam int NL   = eldt_pkg::NUM_LEVELS;

   // Configuration registers.
   logic [eldt_pkg::RATE_BITS-1:0]     rate_ff;
   logic [eldt_pkg::MIN_DUR_BITS-1:0]  min_dur_ff;
   logic [eldt_pkg::SMOOTH_BITS-1:0]   twice_smooth_ff;
   logic [eldt_pkg::RATIO_BITS-1:0]    noise_ratio_ff;
   logic [eldt_pkg::RATIO_BITS-1:0]    peak_ratio_ff;
   logic [DW-1:0]                      floor_ff;
   logic [DW-1:0]                      fixed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff         <= eldt_pkg::RESET_SAMPLE_RATE;
         min_dur_ff      <= eldt_pkg::RESET_MIN_DURATION;
         twice_smooth_ff <= eldt_pkg::RESET_TWICE_SMOOTH;
         noise_ratio_ff  <= eldt_pkg::RESET_NOISE_RATIO;
         peak_ratio_ff   <= eldt_pkg::RESET_PEAK_RATIO;
         floor_ff        <= eldt_pkg::RESET_DURATION_FLOOR;
         fixed_ff        <= eldt_pkg::RESET_FIXED_DURATION;
      end else if (csr_write_en) begin
         unique case (eldt_pkg::eldt_csr_type'(csr_index))
            eldt_pkg::CSR_SAMPLE_RATE: begin
               rate_ff <= csr_write_data[eldt_pkg::RATE_BITS-1:0];
            end
            eldt_pkg::CSR_MIN_DURATION: begin
               min_dur_ff <= csr_write_data[eldt_pkg::MIN_DUR_BITS-1:0];
            end
            eldt_pkg::CSR_TWICE_SMOOTH: begin
               twice_smooth_ff <= csr_write_data[eldt_pkg::SMOOTH_BITS-1:0];
            end
            eldt_pkg::CSR_NOISE_RATIO_END: begin
               noise_ratio_ff <= csr_write_data[eldt_pkg::RATIO_BITS-1:0];
            end
            eldt_pkg::CSR_PEAK_RATIO_END: begin
               peak_ratio_ff <= csr_write_data[eldt_pkg::RATIO_BITS-1:0];
            end
            eldt_pkg::CSR_DURATION_FLOOR: begin
               floor_ff <= csr_write_data[DW-1:0];
            end
            eldt_pkg::CSR_FIXED_DURATION: begin
               fixed_ff <= csr_write_data[DW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Control and tracking state.
   eldt_pkg::eldt_state_type  state_ff, state_in;
   eldt_pkg::eldt_status_type status_ff, status_in;
   logic [PW-1:0]             peak_ff, peak_in;
   logic [IW-1:0]             pos_ff, pos_in;
   logic [PW-1:0]             noise_ff, noise_in;
   logic [IW-1:0]             idx_ff [NL];
   logic [IW-1:0]             idx_in [NL];
   logic [NL-1:0]             armed_ff, armed_in;
   logic [IW-1:0]             count_ff, count_in;
   logic [HW-1:0]             held_ff, held_in;

   // Per-item working registers.
   logic [PW-1:0]             amp_ff, amp_in;
   logic                      first_ff, first_in;
   logic [IW-1:0]             rel_ff, rel_in;
   logic [BB-1:0]             frac_ff, frac_in;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_resolved_ff, rsp_resolved_in;
   logic                      rsp_terminated_ff, rsp_terminated_in;
   logic [DW-1:0]             rsp_duration_ff, rsp_duration_in;
   logic [DW-1:0]             rsp_peak_ff, rsp_peak_in;

   // Serial units.
   logic                      ratio_start;
   logic                      ratio_done_n, ratio_done_p;
   logic [PPW-1:0]            ratio_prod_n, ratio_prod_p;
   logic                      div_start, div_done;
   logic [eldt_pkg::FRAC_BITS-1:0] div_quot;
   logic                      blend_start;
   logic                      blend_done_a, blend_done_b;
   logic [BPW-1:0]            blend_prod_a, blend_prod_b;

   eldt_serial_mul #(.X_BITS(PW), .Y_BITS(eldt_pkg::RATIO_BITS)) u_mul_noise (
      .clock   (clock),
      .reset   (reset),
      .start   (ratio_start),
      .x       (noise_ff),
      .y       (noise_ratio_ff),
      .done    (ratio_done_n),
      .product (ratio_prod_n)
   );

   eldt_serial_mul #(.X_BITS(PW), .Y_BITS(eldt_pkg::RATIO_BITS)) u_mul_peak (
      .clock   (clock),
      .reset   (reset),
      .start   (ratio_start),
      .x       (peak_ff),
      .y       (peak_ratio_ff),
      .done    (ratio_done_p),
      .product (ratio_prod_p)
   );

   // Blend factor: the divisor is 80 times the rate, the dividend the excess over 40 times.
   logic [eldt_pkg::RATE_BITS-1:0] rate_eff;
   logic [DVW-1:0]                 rate_x40, rate_x80, rate_x120;
   logic [SW-1:0]                  level_sum, level_excess;
   logic                           sum_above_low, sum_at_high;

   assign rate_eff     = (rate_ff == '0) ? eldt_pkg::RATE_BITS'(1) : rate_ff;
   assign rate_x40     = DVW'({rate_eff, 5'b0}) + DVW'({rate_eff, 3'b0});
   assign rate_x80     = {rate_x40[DVW-2:0], 1'b0};
   assign rate_x120    = rate_x40 + rate_x80;
   assign level_sum    = SW'(idx_ff[2]) + SW'(idx_ff[1]);
   assign level_excess = level_sum - SW'(rate_x40);
   assign sum_above_low = level_sum > SW'(rate_x40);
   assign sum_at_high   = level_sum >= SW'(rate_x120);

   eldt_serial_div #(.N_BITS(DVW), .Q_BITS(eldt_pkg::FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (level_excess[DVW-1:0]),
      .divisor  (rate_x80),
      .done     (div_done),
      .quotient (div_quot)
   );

   logic [BB-1:0] frac_rest;
   assign frac_rest = eldt_pkg::Q16_ONE - frac_ff;

   eldt_serial_mul #(.X_BITS(IW), .Y_BITS(BB)) u_mul_blend_a (
      .clock   (clock),
      .reset   (reset),
      .start   (blend_start),
      .x       (idx_ff[0]),
      .y       (frac_rest),
      .done    (blend_done_a),
      .product (blend_prod_a)
   );

   eldt_serial_mul #(.X_BITS(IW), .Y_BITS(BB)) u_mul_blend_b (
      .clock   (clock),
      .reset   (reset),
      .start   (blend_start),
      .x       (idx_ff[3]),
      .y       (frac_ff),
      .done    (blend_done_b),
      .product (blend_prod_b)
   );

   logic [BSW-1:0] blend_sum;
   logic [IW-1:0]  blend_dur;
   assign blend_sum = BSW'(blend_prod_a) + BSW'(blend_prod_b) + BSW'(eldt_pkg::Q16_HALF);
   assign blend_dur = blend_sum[IW+eldt_pkg::FRAC_BITS-1:eldt_pkg::FRAC_BITS];

   // Input saturation to the power width.
   logic [AW-1:0] power_ext;
   logic [PW-1:0] amp_sat;
   assign power_ext = AW'(req_ch.power);
   assign amp_sat   = (power_ext > AW'({PW{1'b1}})) ? {PW{1'b1}} : power_ext[PW-1:0];

   // Level comparisons against the current peak.
   logic [CW-1:0] amp_w, peak_w;
   logic [NL-1:0] below;
   assign amp_w    = CW'(amp_ff);
   assign peak_w   = CW'(peak_ff);
   assign below[0] = ((amp_w << 3) + (amp_w << 1)) <= ((peak_w << 3) + peak_w);
   assign below[1] = ((amp_w << 2) + amp_w) <= (peak_w << 2);
   assign below[2] = (amp_w << 1) <= peak_w;
   assign below[3] = ((amp_w << 2) + amp_w) <= peak_w;

   logic ratio_low;
   assign ratio_low = (PPW'({amp_ff, 8'b0}) < ratio_prod_n) ||
                      ({amp_ff, 16'b0} < ratio_prod_p);

   logic [NL-1:0] armed_v;
   logic [IW-1:0] idx_v [NL];
   logic          blend_v;

   always_comb begin
      armed_v = armed_ff;
      blend_v = 1'b0;
      for (int k = 0; k < NL; k++) begin
         idx_v[k] = idx_ff[k];
      end
      for (int k = 0; k < NL; k++) begin
         if (!armed_v[k]) begin
            if (below[k]) begin
               armed_v[k] = 1'b1;
               idx_v[k]   = count_ff;
               if (k == NL - 1) begin
                  blend_v = 1'b1;
               end
            end
         end else if (!below[k]) begin
            for (int j = 0; j < NL; j++) begin
               if (j >= k) begin
                  armed_v[j] = 1'b0;
               end
            end
         end
      end
   end

   logic [HW-1:0] blend_ext, floor_ext;
   logic [HW:0]   held_twice;
   logic          dur_term;
   assign blend_ext  = HW'(blend_dur);
   assign floor_ext  = HW'(floor_ff);
   assign held_twice = {held_ff, 1'b0};
   assign dur_term   = !status_ff.terminated && status_ff.resolved && (held_ff != '0) &&
                       armed_ff[NL-1] && ((HW+1)'(rel_ff) > held_twice) &&
                       (HW'(rel_ff) > HW'(twice_smooth_ff));

   logic [HW-1:0] held_out, pos_out;

   always_comb begin
      state_in          = state_ff;
      status_in         = status_ff;
      peak_in           = peak_ff;
      pos_in            = pos_ff;
      noise_in          = noise_ff;
      armed_in          = armed_ff;
      count_in          = count_ff;
      held_in           = held_ff;
      amp_in            = amp_ff;
      first_in          = first_ff;
      rel_in            = rel_ff;
      frac_in           = frac_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ch.ready;
      rsp_resolved_in   = rsp_resolved_ff;
      rsp_terminated_in = rsp_terminated_ff;
      rsp_duration_in   = rsp_duration_ff;
      rsp_peak_in       = rsp_peak_ff;
      ratio_start       = 1'b0;
      div_start         = 1'b0;
      blend_start       = 1'b0;
      held_out          = held_ff;
      pos_out           = HW'(pos_ff);
      for (int k = 0; k < NL; k++) begin
         idx_in[k] = idx_ff[k];
      end

      unique case (state_ff)
         eldt_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               amp_in   = amp_sat;
               first_in = req_ch.first_sample;
               state_in = eldt_pkg::S_CHECK;
            end
         end
         eldt_pkg::S_CHECK: begin
            if (first_ff) begin
               peak_in   = amp_ff;
               pos_in    = '0;
               noise_in  = (amp_ff == '0) ? PW'(1) : amp_ff;
               armed_in  = '0;
               count_in  = IW'(1);
               held_in   = '0;
               status_in = '{active: 1'b1, resolved: 1'b0, terminated: 1'b0};
               for (int k = 0; k < NL; k++) begin
                  idx_in[k] = '0;
               end
               state_in = eldt_pkg::S_OUT;
            end else if (fixed_ff == '0 && status_ff.active && !status_ff.terminated) begin
               ratio_start = 1'b1;
               state_in    = eldt_pkg::S_MULT;
            end else begin
               state_in = eldt_pkg::S_OUT;
            end
         end
         eldt_pkg::S_MULT: begin
            if (ratio_done_n) begin
               state_in = eldt_pkg::S_EVAL;
            end
         end
         eldt_pkg::S_EVAL: begin
            rel_in   = count_ff;
            count_in = (count_ff == '1) ? count_ff : count_ff + 1'b1;
            if (amp_ff > peak_ff) begin
               peak_in  = amp_ff;
               pos_in   = count_ff;
               armed_in = '0;
               state_in = eldt_pkg::S_DTERM;
            end else begin
               armed_in = armed_v;
               for (int k = 0; k < NL; k++) begin
                  idx_in[k] = idx_v[k];
               end
               if (HW'(count_ff) > HW'(min_dur_ff) && ratio_low) begin
                  status_in.terminated = 1'b1;
               end
               state_in = blend_v ? eldt_pkg::S_DIVSET : eldt_pkg::S_DTERM;
            end
         end
         eldt_pkg::S_DIVSET: begin
            if (!sum_above_low) begin
               frac_in  = '0;
               state_in = eldt_pkg::S_BLEND_GO;
            end else if (sum_at_high) begin
               frac_in  = eldt_pkg::Q16_ONE;
               state_in = eldt_pkg::S_BLEND_GO;
            end else begin
               div_start = 1'b1;
               state_in  = eldt_pkg::S_DIV;
            end
         end
         eldt_pkg::S_DIV: begin
            if (div_done) begin
               frac_in  = BB'(div_quot);
               state_in = eldt_pkg::S_BLEND_GO;
            end
         end
         eldt_pkg::S_BLEND_GO: begin
            blend_start = 1'b1;
            state_in    = eldt_pkg::S_BLEND;
         end
         eldt_pkg::S_BLEND: begin
            if (blend_done_a) begin
               held_in            = (blend_ext < floor_ext) ? floor_ext : blend_ext;
               status_in.resolved = 1'b1;
               state_in           = eldt_pkg::S_DTERM;
            end
         end
         eldt_pkg::S_DTERM: begin
            if (dur_term) begin
               status_in.terminated = 1'b1;
            end
            state_in = eldt_pkg::S_OUT;
         end
         eldt_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               if (fixed_ff != '0) begin
                  status_in.resolved   = 1'b1;
                  status_in.terminated = 1'b1;
                  held_in              = HW'(fixed_ff);
                  pos_in               = '0;
                  held_out             = HW'(fixed_ff);
                  pos_out              = '0;
               end
               rsp_valid_in      = 1'b1;
               rsp_resolved_in   = status_in.resolved;
               rsp_terminated_in = status_in.terminated;
               rsp_duration_in   = (held_out > HW'(eldt_pkg::DURATION_MAX)) ?
                                   eldt_pkg::DURATION_MAX : held_out[DW-1:0];
               rsp_peak_in       = (pos_out > HW'(eldt_pkg::DURATION_MAX)) ?
                                   eldt_pkg::DURATION_MAX : pos_out[DW-1:0];
               state_in          = eldt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = eldt_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= eldt_pkg::S_IDLE;
         status_ff    <= '0;
         peak_ff      <= '0;
         pos_ff       <= '0;
         noise_ff     <= PW'(1);
         armed_ff     <= '0;
         count_ff     <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NL; k++) begin
            idx_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         peak_ff      <= peak_in;
         pos_ff       <= pos_in;
         noise_ff     <= noise_in;
         armed_ff     <= armed_in;
         count_ff     <= count_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < NL; k++) begin
            idx_ff[k] <= idx_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      amp_ff            <= amp_in;
      first_ff          <= first_in;
      rel_ff            <= rel_in;
      frac_ff           <= frac_in;
      rsp_resolved_ff   <= rsp_resolved_in;
      rsp_terminated_ff <= rsp_terminated_in;
      rsp_duration_ff   <= rsp_duration_in;
      rsp_peak_ff       <= rsp_peak_in;
   end

   assign req_ch.ready            = (state_ff == eldt_pkg::S_IDLE);
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.resolved         = rsp_resolved_ff;
   assign rsp_ch.terminated       = rsp_terminated_ff;
   assign rsp_ch.duration_samples = rsp_duration_ff;
   assign rsp_ch.peak_index       = rsp_peak_ff;

   // The paired serial units are started together and must finish together.
   a_units_in_step: assert property (@(posedge clock) disable iff (reset)
      (ratio_done_n == ratio_done_p) && (blend_done_a == blend_done_b))
      else $error("Paired serial units finished in different cycles.");

   // Termination is only ever cleared by a pick item.
   a_term_cleared_by_pick: assert property (@(posedge clock) disable iff (reset)
      ($fell(status_ff.terminated) && !$past(reset)) |->
         ($past(state_ff) == eldt_pkg::S_CHECK && $past(first_ff)))
      else $error("Termination cleared without a pick item.");

   // A new result item is only produced from the output state.
   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && !$past(reset)) |-> ($past(state_ff) == eldt_pkg::S_OUT))
      else $error("Result item raised outside the output state.");

endmodule

[sv/eldt_serial_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
module eldt_serial_mul #(
   parameter int X_BITS = 32,
   parameter int Y_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [X_BITS-1:0]          x,
   input  logic [Y_BITS-1:0]          y,
   output logic                       done,
   output logic [X_BITS+Y_BITS-1:0]   product
);

   localparam int P_BITS   = X_BITS + Y_BITS;
   localparam int CNT_BITS = $clog2(Y_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [X_BITS-1:0]   x_ff, x_in;
   logic [Y_BITS-1:0]   y_ff, y_in;
   logic [P_BITS-1:0]   acc_ff, acc_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(Y_BITS);
         x_in    = x;
         y_in    = y;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = {acc_ff[P_BITS-2:0], 1'b0} + (y_ff[Y_BITS-1] ? P_BITS'(x_ff) : '0);
         y_in   = {y_ff[Y_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

[sv/eldt_serial_div.sv]
// Restoring divider for a fraction below one, one quotient bit per cycle.
module eldt_serial_div #(
   parameter int N_BITS = 17,
   parameter int Q_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [N_BITS-1:0]   dividend,
   input  logic [N_BITS-1:0]   divisor,
   output logic                done,
   output logic [Q_BITS-1:0]   quotient
);

   localparam int CNT_BITS = $clog2(Q_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [N_BITS-1:0]   rem_ff, rem_in;
   logic [N_BITS-1:0]   div_ff, div_in;
   logic [Q_BITS-1:0]   q_ff, q_in;
   logic [N_BITS:0]     rem_shift;
   logic [N_BITS:0]     rem_diff;

   assign rem_shift = {rem_ff, 1'b0};
   assign rem_diff  = rem_shift - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(Q_BITS);
         rem_in  = dividend;
         div_in  = divisor;
         q_in    = '0;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, div_ff}) begin
            rem_in = rem_diff[N_BITS-1:0];
            q_in   = {q_ff[Q_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[N_BITS-1:0];
            q_in   = {q_ff[Q_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

[tb/tb_envelope_level_duration_tracker_core.sv]
// Self-checking testbench for the envelope level duration tracker core.
module tb_envelope_level_duration_tracker_core;
   timeunit 1ns;
   timeprecision 1ps;

   import eldt_pkg::*;

   typedef struct packed {
      logic                     resolved;
      logic                     terminated;
      logic [DURATION_BITS-1:0] duration_samples;
      logic [DURATION_BITS-1:0] peak_index;
   } trk_result_t;

   typedef enum int {LVL_90, LVL_80, LVL_50, LVL_20} level_e;

   logic clock = 1'b0;
   logic reset;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   eldt_req_if req_ch ();
   eldt_rsp_if rsp_ch ();

   envelope_level_duration_tracker_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #2 clock = ~clock;

   // Settings as the block holds them.
   logic [RATE_BITS-1:0]     cfg_rate;
   logic [MIN_DUR_BITS-1:0]  cfg_min_dur;
   logic [SMOOTH_BITS-1:0]   cfg_smooth;
   logic [RATIO_BITS-1:0]    cfg_noise_end;
   logic [RATIO_BITS-1:0]    cfg_peak_end;
   logic [DURATION_BITS-1:0] cfg_floor;
   logic [DURATION_BITS-1:0] cfg_fixed;

   // Tracking state of the predictor.
   logic [POWER_IN_BITS-1:0] pk_level;
   logic [DURATION_BITS-1:0] pk_pos;
   logic [POWER_IN_BITS-1:0] noise_lvl;
   logic [DURATION_BITS-1:0] lvl_idx [NUM_LEVELS];
   logic [NUM_LEVELS-1:0]    lvl_armed;
   logic [DURATION_BITS-1:0] sample_idx;
   logic [DURATION_BITS-1:0] dur_held;
   eldt_status_type          trk_status;

   trk_result_t pending_results [$];
   int          mismatch_count = 0;
   int          live_items = 0;
   bit          req_no_gaps = 1'b0;
   bit          rsp_no_stalls = 1'b0;

   function automatic trk_result_t track_envelope_sample(input logic [31:0] pwr,
                                                          input logic pick);
      logic [63:0] amp, peak, rel, held, rate, sum, frac, blend, noise, ne, pe;
      logic        below;
      trk_result_t res;
      amp = pwr;
      if (pick) begin
         pk_level   = pwr;
         pk_pos     = '0;
         noise_lvl  = (pwr == '0) ? 32'd1 : pwr;
         lvl_idx    = '{default: '0};
         lvl_armed  = '0;
         sample_idx = 20'd1;
         dur_held   = '0;
         trk_status = '{active: 1'b1, resolved: 1'b0, terminated: 1'b0};
      end else if (cfg_fixed == '0 && trk_status.active && !trk_status.terminated) begin
         rel = sample_idx;
         if (sample_idx != '1) begin
            sample_idx = sample_idx + 1'b1;
         end
         peak = pk_level;
         if (amp > peak) begin
            pk_level  = pwr;
            pk_pos    = rel[19:0];
            lvl_armed = '0;
         end else begin
            for (int k = LVL_90; k <= LVL_20; k++) begin
               case (k)
                  LVL_90:  below = 10 * amp <= 9 * peak;
                  LVL_80:  below = 5 * amp <= 4 * peak;
                  LVL_50:  below = 2 * amp <= peak;
                  default: below = 5 * amp <= peak;
               endcase
               if (!lvl_armed[k]) begin
                  if (below) begin
                     lvl_armed[k] = 1'b1;
                     lvl_idx[k]   = rel[19:0];
                     if (k == LVL_20) begin
                        // Blend the 90 and 20 percent times by a Q16 factor.
                        rate = (cfg_rate == '0) ? 64'd1 : {54'd0, cfg_rate};
                        sum  = {44'd0, lvl_idx[LVL_50]} + {44'd0, lvl_idx[LVL_80]};
                        frac = 64'd0;
                        if (sum > 40 * rate) begin
                           frac = ((sum - 40 * rate) << 16) / (80 * rate);
                           if (frac > 64'd65536) begin
                              frac = 64'd65536;
                           end
                        end
                        blend = ({44'd0, lvl_idx[LVL_90]} * (64'd65536 - frac) +
                                 {44'd0, lvl_idx[LVL_20]} * frac + 64'd32768) >> 16;
                        if (blend < {44'd0, cfg_floor}) begin
                           blend = {44'd0, cfg_floor};
                        end
                        dur_held = blend[19:0];
                        trk_status.resolved = 1'b1;
                     end
                  end
               end else if (!below) begin
                  lvl_armed = lvl_armed & ((4'd1 << k) - 4'd1);
               end
            end
            noise = noise_lvl;
            ne    = cfg_noise_end;
            pe    = cfg_peak_end;
            if (rel > {44'd0, cfg_min_dur} &&
                ((amp << 8) < ne * noise || (amp << 16) < pe * peak)) begin
               trk_status.terminated = 1'b1;
            end
         end
         held = dur_held;
         if (!trk_status.terminated && trk_status.resolved && held != 0 &&
             lvl_armed[LVL_20] && rel > 2 * held && rel > {48'd0, cfg_smooth}) begin
            trk_status.terminated = 1'b1;
         end
      end
      if (cfg_fixed != '0) begin
         trk_status.resolved   = 1'b1;
         trk_status.terminated = 1'b1;
         dur_held              = cfg_fixed;
         pk_pos                = '0;
      end
      res.resolved         = trk_status.resolved;
      res.terminated       = trk_status.terminated;
      res.duration_samples = dur_held;
      res.peak_index       = pk_pos;
      return res;
   endfunction

   task automatic send_item(input logic [31:0] pwr, input logic pick);
      int gap;
      gap = req_no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.power        <= pwr;
      req_ch.first_sample <= pick;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (pick || cfg_fixed != '0 || (trk_status.active && !trk_status.terminated)) begin
         live_items++;
      end
      pending_results.push_back(track_envelope_sample(pwr, pick));
   endtask

   task automatic wait_results_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic load_settings(input logic [9:0] rate, input logic [19:0] min_dur,
                                input logic [15:0] smooth, input logic [15:0] noise_end,
                                input logic [15:0] peak_end, input logic [19:0] floor_dur,
                                input logic [19:0] fixed_dur);
      logic [CSR_DATA_BITS-1:0] values [7];
      values[CSR_SAMPLE_RATE]     = rate;
      values[CSR_MIN_DURATION]    = min_dur;
      values[CSR_TWICE_SMOOTH]    = smooth;
      values[CSR_NOISE_RATIO_END] = noise_end;
      values[CSR_PEAK_RATIO_END]  = peak_end;
      values[CSR_DURATION_FLOOR]  = floor_dur;
      values[CSR_FIXED_DURATION]  = fixed_dur;
      wait_results_drained();
      csr_write_en <= 1'b1;
      for (int i = CSR_SAMPLE_RATE; i <= CSR_FIXED_DURATION; i++) begin
         csr_index      <= eldt_csr_type'(i);
         csr_write_data <= values[i];
         @(posedge clock);
      end
      csr_write_en  <= 1'b0;
      cfg_rate      = rate;
      cfg_min_dur   = min_dur;
      cfg_smooth    = smooth;
      cfg_noise_end = noise_end;
      cfg_peak_end  = peak_end;
      cfg_floor     = floor_dur;
      cfg_fixed     = fixed_dur;
   endtask

   // A pick, a rise to a peak, then a noisy decay that may bump back up.
   task automatic play_envelope_event();
      logic [63:0] level, peak, noise;
      int          rise_len, total_len;
      req_no_gaps = ($urandom_range(0, 4) == 0);
      noise = $urandom >> $urandom_range(12, 31);
      if ($urandom_range(0, 9) == 0) begin
         noise = 0;
      end
      peak = noise + 1 + ($urandom >> $urandom_range(0, 20));
      if ($urandom_range(0, 9) == 0 || peak > 64'hFFFF_FFFF) begin
         peak = 64'hFFFF_FFFF;
      end
      send_item(noise[31:0], 1'b1);
      level     = noise;
      rise_len  = $urandom_range(1, 40);
      total_len = rise_len + $urandom_range(10, 80);
      for (int i = 1; i <= total_len; i++) begin
         if (i <= rise_len) begin
            level = noise + (peak - noise) * i / rise_len;
         end else begin
            level = level * $urandom_range(78, 98) / 100;
            if ($urandom_range(0, 9) == 0) begin
               level = level * $urandom_range(101, 140) / 100;
            end
         end
         if (level > 64'hFFFF_FFFF) begin
            level = 64'hFFFF_FFFF;
         end
         send_item(level[31:0], 1'b0);
         if (trk_status.terminated && $urandom_range(0, 3) != 0) begin
            break;
         end
      end
   endtask

   task automatic play_noise_burst();
      int count;
      count = $urandom_range(1, 6);
      req_no_gaps = ($urandom_range(0, 3) == 0);
      repeat (count) send_item($urandom, $urandom_range(0, 7) == 0);
   endtask

   task automatic run_search(input int target);
      int start;
      start = live_items;
      while (live_items - start < target) begin
         case ($urandom_range(0, 19))
            0, 1, 2: play_noise_burst();
            3:       wait_results_drained();
            default: play_envelope_event();
         endcase
      end
   endtask

   task automatic test_directed_levels();
      send_item(32'd123, 1'b0);
      send_item(32'd0, 1'b1);
      send_item(32'hFFFF_FFFF, 1'b0);
      send_item(32'hE666_6666, 1'b0);
      send_item(32'hE666_6665, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b0);
      send_item(32'hCCCC_CCCC, 1'b0);
      send_item(32'h7FFF_FFFF, 1'b0);
      send_item(32'h3333_3333, 1'b0);
      send_item(32'h0000_0000, 1'b0);
      send_item(32'h5000_0000, 1'b0);
      send_item(32'h1000_0000, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b1);
      send_item(32'h0000_0000, 1'b0);
      load_settings(10'd1, 20'd0, 16'd0, 16'd512, 16'd3277, 20'd0, 20'd0);
      send_item(32'd1000, 1'b1);
      send_item(32'd100000, 1'b0);
      send_item(32'd50000, 1'b0);
      send_item(32'd1500, 1'b0);
      send_item(32'd99999, 1'b0);
   endtask

   task automatic test_fixed_duration();
      load_settings(10'd100, 20'd1000, 16'd200, 16'd512, 16'd3277, 20'd500, 20'hFFFFF);
      send_item(32'h0000_0001, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b1);
      send_item(32'h0000_0000, 1'b0);
      load_settings(10'd100, 20'd1000, 16'd200, 16'd512, 16'd3277, 20'd500,
                    $urandom_range(1, 20'hFFFFE));
      run_search(40);
   endtask

   task automatic test_typical_search();
      repeat (4) begin
         load_settings($urandom_range(1, 3), $urandom_range(0, 30), $urandom_range(0, 60),
                       $urandom_range(256, 1024), $urandom_range(1000, 8000),
                       $urandom_range(0, 20), 20'd0);
         run_search(130);
      end
   endtask

   task automatic test_duration_termination();
      repeat (2) begin
         load_settings($urandom_range(1, 2), $urandom_range(0, 20), $urandom_range(0, 30),
                       16'd0, 16'd0, $urandom_range(0, 10), 20'd0);
         run_search(150);
      end
   endtask

   task automatic test_early_termination();
      load_settings(10'd1, $urandom_range(5, 25), 16'd0, 16'hFFFF, 16'hFFFF, 20'd0, 20'd0);
      run_search(150);
   endtask

   task automatic test_zero_settings();
      load_settings(10'd0, 20'd0, 16'd0, 16'd0, 16'd0, 20'd0, 20'd0);
      run_search(200);
   endtask

   task automatic test_largest_settings();
      load_settings(10'd1000, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'd0);
      run_search(150);
   endtask

   function automatic void check_field(input string name, input logic [19:0] want,
                                       input logic [19:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   initial begin : result_checker
      int          stall;
      trk_result_t want;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) begin
            rsp_no_stalls = !rsp_no_stalls;
         end
         stall = rsp_no_stalls ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         if (pending_results.size() == 0) begin
            $display("%0t: result with no item pending, expected none, actual %b %b %0d %0d",
                     $time, rsp_ch.resolved, rsp_ch.terminated, rsp_ch.duration_samples,
                     rsp_ch.peak_index);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("resolved", want.resolved, rsp_ch.resolved);
            check_field("terminated", want.terminated, rsp_ch.terminated);
            check_field("duration_samples", want.duration_samples, rsp_ch.duration_samples);
            check_field("peak_index", want.peak_index, rsp_ch.peak_index);
         end
      end
   end

   initial begin
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.power        <= '0;
      req_ch.first_sample <= 1'b0;
      csr_write_en        <= 1'b0;
      csr_index           <= CSR_SAMPLE_RATE;
      csr_write_data      <= '0;
      cfg_rate      = RESET_SAMPLE_RATE;
      cfg_min_dur   = RESET_MIN_DURATION;
      cfg_smooth    = RESET_TWICE_SMOOTH;
      cfg_noise_end = RESET_NOISE_RATIO;
      cfg_peak_end  = RESET_PEAK_RATIO;
      cfg_floor     = RESET_DURATION_FLOOR;
      cfg_fixed     = RESET_FIXED_DURATION;
      pk_level      = '0;
      pk_pos        = '0;
      noise_lvl     = 32'd1;
      lvl_idx       = '{default: '0};
      lvl_armed     = '0;
      sample_idx    = '0;
      dur_held      = '0;
      trk_status    = '{active: 1'b0, resolved: 1'b0, terminated: 1'b0};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_levels();
      test_fixed_duration();
      test_typical_search();
      test_duration_termination();
      test_early_termination();
      test_zero_settings();
      test_largest_settings();
      wait_results_drained();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("** envelope_level_duration_tracker_core: PASSED **");
      end else begin
         $display("** envelope_level_duration_tracker_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("** envelope_level_duration_tracker_core: FAILED **");
      $finish;
   end

endmodule
